// ----- rtl/core/maes_pkg.sv -----
// ----------------------------------------------------------------------------
// maes_pkg: shared types, constants and functions for the masked AES-128 core
// Holds the S-box, round constants, GF(2^8) helpers and the command struct.
// ----------------------------------------------------------------------------
package maes_pkg;

	localparam logic [31:0] GEN_RESET    = 32'h1234abcd;
	localparam logic [31:0] GEN_ZERO_SUB = 32'ha5a5a5a5;
	localparam logic [7:0]  GF_POLY      = 8'h1b;

	localparam int KEY_BYTES = 176;
	localparam int SBOX_SIZE = 256;

	// register byte addresses, 8-byte spacing
	localparam logic [4:0] ADDR_KEY_HIGH  = 5'd0;
	localparam logic [4:0] ADDR_KEY_LOW   = 5'd8;
	localparam logic [4:0] ADDR_MASK_SEED = 5'd16;

	typedef struct packed {
		logic pt_load;      // capture the plaintext of an accepted request
		logic key_load;     // copy key registers into round key 0 and restart expansion
		logic key_step;     // compute next round key
		logic gen_step;     // advance xorshift generator
		logic take_min;
		logic take_mout;
		logic sbox_write;   // write one masked S-box entry
		logic load_state;   // load plaintext byte with fresh mask
		logic add_key;      // xor round key into masked state
		logic sub_byte;     // one masked S-box byte lookup
		logic sub_done;     // apply ShiftRows/MixColumns and key for the round
		logic last_round;
		logic out_load;
	} maes_cmd_t;

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] t [0:255];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[x];
	endfunction

	function automatic logic [7:0] rcon(input logic [3:0] r);
		logic [7:0] v;
		case (r)
			4'd0: v = 8'h01;
			4'd1: v = 8'h02;
			4'd2: v = 8'h04;
			4'd3: v = 8'h08;
			4'd4: v = 8'h10;
			4'd5: v = 8'h20;
			4'd6: v = 8'h40;
			4'd7: v = 8'h80;
			4'd8: v = GF_POLY;
			4'd9: v = 8'h36;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] dbl(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
	endfunction

	function automatic logic [31:0] xorshift(input logic [31:0] x);
		logic [31:0] a, b;
		a = x ^ (x << 13);
		b = a ^ (a >> 17);
		return b ^ (b << 5);
	endfunction

	function automatic logic [127:0] rotate_rows(input logic [127:0] s);
		logic [127:0] o;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				o[127 - 8*(4*c + r) -: 8] = s[127 - 8*(4*((c + r) % 4) + r) -: 8];
			end
		end
		return o;
	endfunction

	function automatic logic [127:0] mix_cols(input logic [127:0] s);
		logic [127:0] o;
		logic [7:0] a0, a1, a2, a3, al;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127 - 32*c -: 8];
			a1 = s[119 - 32*c -: 8];
			a2 = s[111 - 32*c -: 8];
			a3 = s[103 - 32*c -: 8];
			al = a0 ^ a1 ^ a2 ^ a3;
			o[127 - 32*c -: 8] = a0 ^ al ^ dbl(a0 ^ a1);
			o[119 - 32*c -: 8] = a1 ^ al ^ dbl(a1 ^ a2);
			o[111 - 32*c -: 8] = a2 ^ al ^ dbl(a2 ^ a3);
			o[103 - 32*c -: 8] = a3 ^ al ^ dbl(a3 ^ a0);
		end
		return o;
	endfunction

endpackage

// ----- rtl/core/maes_datapath.sv -----
// ----------------------------------------------------------------------------
// maes_datapath: masked AES datapath
// Round key generator, mask generator, masked S-box memory and state.
// ----------------------------------------------------------------------------
module maes_datapath import maes_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  maes_cmd_t    cmd,
	input  logic [7:0]   idx,          // S-box fill index or byte index
	input  logic [3:0]   round,
	input  logic         seed_write,
	input  logic [31:0]  seed,
	input  logic [127:0] key,
	input  logic [127:0] plaintext,
	output logic [127:0] ciphertext
);

	logic [31:0]  gen_q;
	logic [7:0]   min_q, mout_q;
	logic [127:0] rk_q;                // current round key
	logic [127:0] rk_next;
	logic [127:0] st_q, mk_q;          // masked state and mask per byte
	logic [127:0] pt_q;
	logic [7:0]   msbox_mem [0:SBOX_SIZE-1];
	logic [7:0]   rd_q;
	logic [127:0] sr_st, sr_mk, mc_st, mc_mk;
	logic [31:0]  gen_next;

	assign gen_next = xorshift(gen_q);

	always_comb begin
		logic [31:0] w;
		w = rk_q[31:0];
		w = {sbox(w[23:16]) ^ rcon(round), sbox(w[15:8]), sbox(w[7:0]), sbox(w[31:24])};
		rk_next[127:96] = rk_q[127:96] ^ w;
		rk_next[95:64]  = rk_q[95:64]  ^ rk_next[127:96];
		rk_next[63:32]  = rk_q[63:32]  ^ rk_next[95:64];
		rk_next[31:0]   = rk_q[31:0]   ^ rk_next[63:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= GEN_RESET;
		end else if (seed_write) begin
			gen_q <= (seed == 32'd0) ? GEN_ZERO_SUB : seed;
		end else if (cmd.gen_step) begin
			gen_q <= gen_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.key_load) begin
			rk_q <= key;
		end else if (cmd.key_step) begin
			rk_q <= rk_next;
		end
		if (cmd.take_min) begin
			min_q <= gen_next[7:0];
		end
		if (cmd.take_mout) begin
			mout_q <= gen_next[7:0];
		end
		if (cmd.sbox_write) begin
			msbox_mem[idx ^ min_q] <= sbox(idx) ^ mout_q;
		end
		rd_q <= msbox_mem[st_q[127 - 8*idx[3:0] -: 8] ^ mk_q[127 - 8*idx[3:0] -: 8] ^ min_q];
	end

	assign sr_st = rotate_rows(st_q);
	assign sr_mk = rotate_rows(mk_q);
	assign mc_st = mix_cols(sr_st);
	assign mc_mk = mix_cols(sr_mk);

	always_ff @(posedge clk) begin
		if (cmd.pt_load) begin
			pt_q <= plaintext;
		end
		if (cmd.load_state) begin
			mk_q[127 - 8*idx[3:0] -: 8] <= gen_next[7:0];
			st_q[127 - 8*idx[3:0] -: 8] <= pt_q[127 - 8*idx[3:0] -: 8] ^ gen_next[7:0];
		end else if (cmd.add_key) begin
			st_q <= st_q ^ rk_q;
		end else if (cmd.sub_byte) begin
			// rd_q holds this byte's lookup, read in the cycle before
			st_q[127 - 8*idx[3:0] -: 8] <= rd_q;
			mk_q[127 - 8*idx[3:0] -: 8] <= mout_q;
		end else if (cmd.sub_done) begin
			if (cmd.last_round) begin
				st_q <= sr_st ^ rk_q;
				mk_q <= sr_mk;
			end else begin
				st_q <= mc_st ^ rk_q;
				mk_q <= mc_mk;
			end
		end
		if (cmd.out_load) begin
			ciphertext <= st_q ^ mk_q;
		end
	end

endmodule

// ----- rtl/core/maes_ctrl.sv -----
// ----------------------------------------------------------------------------
// maes_ctrl: sequencer for the masked AES core
// Steps key expansion, S-box rebuild, masking and ten byte-serial rounds.
// ----------------------------------------------------------------------------
module maes_ctrl import maes_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       key_write,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	output maes_cmd_t  cmd,
	output logic [7:0] idx,
	output logic [3:0] round
);

	typedef enum logic [3:0] {
		IDLE, MIN, MOUT, FILL, LOAD, ADDK, KLOAD, SUBA, SUBB, MIX, DONE
	} state_t;

	state_t     state_q;
	logic [7:0] cnt_q;
	logic [3:0] round_q;
	logic       sub_wr;

	assign idx       = cnt_q;
	assign round     = round_q;
	assign in_stall  = (state_q != IDLE) || key_write;
	assign sub_wr    = (state_q == SUBB);

	always_comb begin
		cmd = '0;
		case (state_q)
			IDLE:  cmd.pt_load = in_valid && !in_stall;
			MIN:   begin cmd.gen_step = 1'b1; cmd.take_min = 1'b1; end
			MOUT:  begin cmd.gen_step = 1'b1; cmd.take_mout = 1'b1; end
			FILL:  cmd.sbox_write = 1'b1;
			LOAD:  begin cmd.gen_step = 1'b1; cmd.load_state = 1'b1; end
			KLOAD: cmd.key_load = 1'b1;
			ADDK:  begin cmd.add_key = 1'b1; cmd.key_step = 1'b1; end
			SUBB:  cmd.sub_byte = sub_wr;
			MIX:   begin
				cmd.sub_done   = 1'b1;
				cmd.key_step   = 1'b1;
				cmd.last_round = (round_q == 4'd10);
			end
			DONE:  cmd.out_load = !out_valid;
			default: cmd = '0;
		endcase
		// a key write reloads round key 0 with the pre-write key; writes belong in idle, not enforced here
		if (key_write) begin
			cmd.key_load = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			cnt_q     <= '0;
			round_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				IDLE: if (in_valid && !in_stall) state_q <= MIN;
				MIN:  state_q <= MOUT;
				MOUT: begin state_q <= FILL; cnt_q <= '0; end
				FILL: begin
					cnt_q <= cnt_q + 8'd1;
					if (cnt_q == 8'hff) begin
						state_q <= LOAD;
					end
				end
				LOAD: begin
					cnt_q <= cnt_q + 8'd1;
					if (cnt_q == 8'd15) begin
						state_q <= KLOAD;
					end
				end
				KLOAD: begin state_q <= ADDK; round_q <= '0; end
				ADDK: begin state_q <= SUBA; cnt_q <= '0; round_q <= 4'd1; end
				SUBA: state_q <= SUBB;          // read latency of the S-box memory
				SUBB: begin
					if (cnt_q == 8'd15) begin
						state_q <= MIX;
					end else begin
						cnt_q   <= cnt_q + 8'd1;
						state_q <= SUBA;
					end
				end
				MIX: begin
					cnt_q <= '0;
					if (round_q == 4'd10) begin
						state_q <= DONE;
					end else begin
						round_q <= round_q + 4'd1;
						state_q <= SUBA;
					end
				end
				DONE: if (!out_valid) begin
					out_valid <= 1'b1;
					state_q   <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/masked_aes128_encrypt.sv -----
// ----------------------------------------------------------------------------
// masked_aes128_encrypt: first-order masked AES-128 encryption core
// Steps from accepted request to result valid: 2 mask draws, a masked S-box
// rebuild of 256 entries, masking of 16 bytes, key load and key add, 10 rounds of
// 16 S-box lookups (read state, write state) plus a mix step, then the output step.
// One block at a time; the output step holds while a result still waits. Reset
// clears control, loads the all-zero key and seed 0x1234abcd.
// ----------------------------------------------------------------------------
module masked_aes128_encrypt import maes_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] plaintext_high,
	input  logic [63:0] plaintext_low,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] ciphertext_high,
	output logic [63:0] ciphertext_low
);

	logic [63:0]  key_high_q, key_low_q;
	logic [31:0]  seed_q;
	logic         wr, key_write, seed_write;
	maes_cmd_t    cmd;
	logic [7:0]   idx;
	logic [3:0]   round;
	logic [127:0] ct;

	assign pready     = 1'b1;
	assign wr         = psel && penable && pwrite;
	assign key_write  = wr && (paddr == ADDR_KEY_HIGH || paddr == ADDR_KEY_LOW);
	assign seed_write = wr && (paddr == ADDR_MASK_SEED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			seed_q     <= GEN_RESET;
		end else if (wr) begin
			case (paddr)
				ADDR_KEY_HIGH:  key_high_q <= pwdata;
				ADDR_KEY_LOW:   key_low_q  <= pwdata;
				ADDR_MASK_SEED: seed_q     <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			ADDR_KEY_HIGH:  prdata = key_high_q;
			ADDR_KEY_LOW:   prdata = key_low_q;
			ADDR_MASK_SEED: prdata = {32'd0, seed_q};
			default:        prdata = '0;
		endcase
	end

	maes_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_write (key_write),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.idx       (idx),
		.round     (round)
	);

	maes_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.idx        (idx),
		.round      (round),
		.seed_write (seed_write),
		.seed       (pwdata[31:0]),
		.key        ({key_high_q, key_low_q}),
		.plaintext  ({plaintext_high, plaintext_low}),
		.ciphertext (ct)
	);

	assign ciphertext_high = ct[127:64];
	assign ciphertext_low  = ct[63:0];

endmodule
